// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = COLUMNS * ROWS;
	localparam int MOVE_CELLS = COLUMNS * (ROWS - 1);
	localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int IDX_W     = 11;
	localparam int LIN_W     = 12;
	localparam int CELL_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_SET   = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ATTR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_ATTR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_CHAR  = 2'd2;

	localparam logic [BYTE_W-1:0] WRITE_ATTR_RST = 8'd240;
	localparam logic [BYTE_W-1:0] FILL_ATTR_RST  = 8'd240;
	localparam logic [BYTE_W-1:0] FILL_CHAR_RST  = 8'd32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		cell_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] cursor_index;
		cell_t            cell_data;
	} result_t;

	// row * COLUMNS + column, wide enough for any legal geometry
	function automatic logic [LIN_W-1:0] lin_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		return LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
	endfunction

	function automatic logic in_screen(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
		return ({1'b0, c} < 8'(COLUMNS)) && ({1'b0, r} < 6'(ROWS));
	endfunction

endpackage

// ===== rtl/core/tcw_if.sv =====
`timescale 1ns / 1ps
// Command and response channel interfaces of the text console writer.
interface tcw_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::OP_W-1:0]      operation;
	logic [tcw_pkg::BYTE_W-1:0]    character;
	logic [tcw_pkg::COL_W-1:0]     column;
	logic [tcw_pkg::ROW_W-1:0]     row;

	modport source (output valid, operation, character, column, row, input ready);
	modport sink   (input valid, operation, character, column, row, output ready);
endinterface

interface tcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [tcw_pkg::IDX_W-1:0]     cursor_index;
	logic [tcw_pkg::CELL_W-1:0]    cell_data;

	modport source (output valid, status, cursor_index, cell_data, input ready);
	modport sink   (input valid, status, cursor_index, cell_data, output ready);
endinterface

// ===== rtl/core/tcw_screen_mem.sv =====
`timescale 1ns / 1ps
// Screen cell store: one write port, one registered read port.
module tcw_screen_mem (
	input  logic              clk,
	input  tcw_pkg::mem_req_t req,
	output tcw_pkg::cell_t    rd_data
);

	tcw_pkg::cell_t mem [tcw_pkg::CELLS];
	tcw_pkg::cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// Command sequencer: cursor, attribute registers and the store sweep engine.
module tcw_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::BYTE_W-1:0]        cfg_data,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [tcw_pkg::OP_W-1:0]          cmd_op,
	input  logic [tcw_pkg::BYTE_W-1:0]        cmd_char,
	input  logic [tcw_pkg::COL_W-1:0]         cmd_col,
	input  logic [tcw_pkg::ROW_W-1:0]         cmd_row,
	output logic                              res_valid,
	input  logic                              res_ready,
	output tcw_pkg::result_t                  res,
	output tcw_pkg::mem_req_t                 mem_req,
	input  tcw_pkg::cell_t                    mem_rdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_RESP  = 2'd2;

	localparam logic [1:0] MODE_ZERO   = 2'd0;
	localparam logic [1:0] MODE_FILL   = 2'd1;
	localparam logic [1:0] MODE_SCROLL = 2'd2;

	localparam logic [tcw_pkg::COL_W-1:0] LAST_COL  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
	localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	localparam tcw_pkg::addr_t            LAST_ADDR = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
	localparam tcw_pkg::addr_t            MOVE_END  = tcw_pkg::ADDR_W'(tcw_pkg::MOVE_CELLS);
	localparam tcw_pkg::addr_t            ROW_STEP  = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

	logic [1:0]                   state_q;
	logic [1:0]                   mode_q;
	logic                         run_q;
	tcw_pkg::addr_t               cnt_q;
	logic                         wr_valid_s1;
	tcw_pkg::addr_t               wr_addr_s1;
	logic                         wr_copy_s1;
	logic [tcw_pkg::COL_W-1:0]    col_q;
	logic [tcw_pkg::ROW_W-1:0]    row_q;
	logic [tcw_pkg::BYTE_W-1:0]   wattr_q;
	logic [tcw_pkg::BYTE_W-1:0]   fattr_q;
	logic [tcw_pkg::BYTE_W-1:0]   fchar_q;
	logic                         status_q;
	logic                         cell_sel_q;

	logic                         accept;
	logic                         cmd_inside;
	logic [tcw_pkg::LIN_W-1:0]    cur_lin;
	logic [tcw_pkg::LIN_W-1:0]    cmd_lin;
	logic                         copy_now;
	tcw_pkg::cell_t               blank;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign accept     = cmd_valid && cmd_ready;
	assign cmd_inside = tcw_pkg::in_screen(cmd_col, cmd_row);
	assign cur_lin    = tcw_pkg::lin_index(row_q, col_q);
	assign cmd_lin    = tcw_pkg::lin_index(cmd_row, cmd_col);
	assign copy_now   = (mode_q == MODE_SCROLL) && (cnt_q < MOVE_END);
	assign blank      = (mode_q == MODE_ZERO) ? '0 : {fattr_q, fchar_q};

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_op == tcw_pkg::OP_PUT) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = tcw_pkg::ADDR_W'(cur_lin);
					mem_req.wdata = {wattr_q, cmd_char};
				end
				if (accept && cmd_op == tcw_pkg::OP_READ) begin
					mem_req.re    = cmd_inside;
					mem_req.raddr = tcw_pkg::ADDR_W'(cmd_lin);
				end
			end
			ST_SWEEP: begin
				// read one row ahead, write the cell back one stage later
				mem_req.re    = run_q && copy_now;
				mem_req.raddr = cnt_q + ROW_STEP;
				mem_req.we    = wr_valid_s1;
				mem_req.waddr = wr_addr_s1;
				mem_req.wdata = wr_copy_s1 ? mem_rdata : blank;
			end
			default: begin
			end
		endcase
	end

	assign res_valid        = (state_q == ST_RESP);
	assign res.status       = status_q;
	assign res.cursor_index = tcw_pkg::IDX_W'(cur_lin);
	assign res.cell_data    = cell_sel_q ? mem_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			mode_q      <= MODE_ZERO;
			run_q       <= 1'b1;
			cnt_q       <= '0;
			wr_valid_s1 <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			wattr_q     <= tcw_pkg::WRITE_ATTR_RST;
			fattr_q     <= tcw_pkg::FILL_ATTR_RST;
			fchar_q     <= tcw_pkg::FILL_CHAR_RST;
			status_q    <= 1'b0;
			cell_sel_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::CFG_WRITE_ATTR: wattr_q <= cfg_data;
					tcw_pkg::CFG_FILL_ATTR:  fattr_q <= cfg_data;
					tcw_pkg::CFG_FILL_CHAR:  fchar_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q   <= 1'b0;
						cell_sel_q <= 1'b0;
						state_q    <= ST_RESP;
						unique case (cmd_op)
							tcw_pkg::OP_PUT: begin
								if (col_q == LAST_COL) begin
									col_q <= '0;
									if (row_q == LAST_ROW) begin
										state_q <= ST_SWEEP;
										mode_q  <= MODE_SCROLL;
										run_q   <= 1'b1;
										cnt_q   <= '0;
									end else begin
										row_q <= row_q + 1'b1;
									end
								end else begin
									col_q <= col_q + 1'b1;
								end
							end
							tcw_pkg::OP_CLEAR: begin
								wattr_q <= fattr_q;
								col_q   <= '0;
								row_q   <= '0;
								state_q <= ST_SWEEP;
								mode_q  <= MODE_FILL;
								run_q   <= 1'b1;
								cnt_q   <= '0;
							end
							tcw_pkg::OP_SET: begin
								if (cmd_inside) begin
									col_q <= cmd_col;
									row_q <= cmd_row;
								end else begin
									status_q <= 1'b1;
								end
							end
							tcw_pkg::OP_READ: begin
								cell_sel_q <= cmd_inside;
								status_q   <= !cmd_inside;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SWEEP: begin
					wr_valid_s1 <= run_q;
					wr_addr_s1  <= cnt_q;
					wr_copy_s1  <= copy_now;
					if (run_q) begin
						if (cnt_q == LAST_ADDR) begin
							run_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (!run_q && !wr_valid_s1) begin
						state_q <= (mode_q == MODE_ZERO) ? ST_IDLE : ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// Top level of the text console writer: screen store, sequencer and response register.
//
// A character-cell screen of COLUMNS x ROWS 16-bit cells (attribute in the high byte,
// character in the low byte) held in one synchronous RAM with a single write and a single
// registered read port. Commands arrive on the cmd channel one at a time; every command
// gives exactly one response beat carrying a status bit, the linear cursor index for the
// CRTC and, for a read, the cell. Put, set-position and read touch the RAM or move the
// cursor when taken, then hand the response to the output register. Clear and a put that
// wraps on the last row walk the whole store one cell per cycle through the RAM's single
// write port; a scroll copies each cell up one row by reading one row ahead and writing
// it back in the cycle after. After reset the block zeroes the store the same way, with
// cmd.ready held low meanwhile; configuration writes are taken throughout. The response
// register decouples the two sides, so the next command is taken while the previous
// response still waits. Configuration: index 0 write attribute, 1 fill attribute, 2 fill
// character; a clear also copies the fill attribute into the write attribute.
module text_console_writer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	tcw_cmd_if.sink                       cmd,
	tcw_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::BYTE_W-1:0]    cfg_data
);

	tcw_pkg::mem_req_t mem_req;
	tcw_pkg::cell_t    mem_rdata;
	tcw_pkg::result_t  res;
	logic              res_valid;
	logic              res_ready;

	logic              out_valid_q;
	tcw_pkg::result_t  out_data_q;

	// RAM holding the screen; the sequencer owns both of its ports
	tcw_screen_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rdata)
	);

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.cmd_op    (cmd.operation),
		.cmd_char  (cmd.character),
		.cmd_col   (cmd.column),
		.cmd_row   (cmd.row),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Load a new response when the register is empty or its beat leaves this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; hold it while the beat is stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_data_q.status;
	assign rsp.cursor_index = out_data_q.cursor_index;
	assign rsp.cell_data    = out_data_q.cell_data;

endmodule

// ===== rtl/core/tcw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the text console writer, bound to the top level.
module tcw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic [tcw_pkg::OP_W-1:0]    operation,
	input logic [tcw_pkg::COL_W-1:0]   column,
	input logic [tcw_pkg::ROW_W-1:0]   row,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        status,
	input logic [tcw_pkg::IDX_W-1:0]   cursor_index,
	input logic [tcw_pkg::CELL_W-1:0]  cell_data
);

	logic                      cmd_acc;
	logic                      cmd_inside;
	logic [tcw_pkg::LIN_W-1:0] cmd_lin;

	assign cmd_acc    = cmd_valid && cmd_ready;
	assign cmd_inside = tcw_pkg::in_screen(column, row);
	assign cmd_lin    = tcw_pkg::lin_index(row, column);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(cursor_index) && $stable(cell_data))
		else $error("response beat changed while stalled");

	// one command at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd_ready)
		else $error("command taken while the previous one is in flight");

	// a legal set-position is answered with the new cursor
	a_set_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && operation == tcw_pkg::OP_SET && cmd_inside && !rsp_valid
		|-> ##2 rsp_valid && !status
			&& cursor_index == tcw_pkg::IDX_W'($past(cmd_lin, 2)))
		else $error("set-position response wrong");

	// an off-screen set or read is flagged and returns no cell
	a_off_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (operation == tcw_pkg::OP_SET || operation == tcw_pkg::OP_READ)
			&& !cmd_inside && !rsp_valid
		|-> ##2 rsp_valid && status && cell_data == '0)
		else $error("off-screen request not flagged");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.operation    (cmd.operation),
	.column       (cmd.column),
	.row          (cmd.row),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.cursor_index (rsp.cursor_index),
	.cell_data    (rsp.cell_data)
);

// ===== verif/tb_text_console_writer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the text console writer: directed table, random phases.
module tb_text_console_writer_core;
	import tcw_pkg::*;

	// Status codes of a response beat.
	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_OUTSIDE = 1'b1;

	// Spare register index: writes to it must leave the block untouched.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Whether a directed row carries its own expected response or takes the predictor's.
	localparam logic PREDICT = 1'b0;
	localparam logic GIVEN   = 1'b1;

	// Cycles without any beat on either side before the run is abandoned. The slowest
	// legal stretch is the post-reset zeroing or a clear or scroll walk plus the longest
	// receiver stall and sender gap; allow several times that.
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 100;
	localparam int DIR_N          = 25;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              given;
		result_t           res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	tcw_cmd_if cmd_ch();
	tcw_rsp_if rsp_ch();

	text_console_writer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Own copy of the console: screen, cursor and the three registers.
	cell_t             screen_copy [CELLS];
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [BYTE_W-1:0] put_attr;
	logic [BYTE_W-1:0] blank_attr;
	logic [BYTE_W-1:0] blank_char;

	result_t due_responses [$];
	int      errors       = 0;
	int      quiet_cycles = 0;
	int      items_sent   = 0;
	logic    smooth       = 1'b0;
	logic    given_next   = 1'b0;
	result_t given_res    = '0;
	int      ready_hold   = 0;

	// Registers during the directed part: write 0xFF, fill attribute 0x00, fill char 0xFF.
	// Expected beats are typed in where they follow at a glance from reset, the
	// extremes and out-of-screen requests; the rest go through the predictor.
	dir_row_t directed_steps [DIR_N] = '{
		// untouched store reads as zero, cursor at home
		'{OP_READ,  8'h00,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd0,    16'h0000}},
		'{OP_READ,  8'h00, 7'd79, 5'd24, GIVEN,   '{ST_DONE,    11'd0,    16'h0000}},
		// off the screen: column only, row only, both at their field maxima
		'{OP_READ,  8'h00, 7'd80,  5'd0, GIVEN,   '{ST_OUTSIDE, 11'd0,    16'h0000}},
		'{OP_READ,  8'h00, 7'd127, 5'd31, GIVEN,  '{ST_OUTSIDE, 11'd0,    16'h0000}},
		'{OP_SET,   8'h00, 7'd127, 5'd31, GIVEN,  '{ST_OUTSIDE, 11'd0,    16'h0000}},
		'{OP_SET,   8'h00,  7'd0, 5'd25, GIVEN,   '{ST_OUTSIDE, 11'd0,    16'h0000}},
		'{OP_SET,   8'h00, 7'd80, 5'd24, GIVEN,   '{ST_OUTSIDE, 11'd0,    16'h0000}},
		// last cell, then a put that wraps on the last row and scrolls
		'{OP_SET,   8'h00, 7'd79, 5'd24, GIVEN,   '{ST_DONE,    11'd1999, 16'h0000}},
		'{OP_PUT,   8'hFF,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd1920, 16'h0000}},
		'{OP_READ,  8'h00, 7'd79, 5'd23, GIVEN,   '{ST_DONE,    11'd1920, 16'hFFFF}},
		'{OP_READ,  8'h00,  7'd0, 5'd24, GIVEN,   '{ST_DONE,    11'd1920, 16'h00FF}},
		'{OP_PUT,   8'h00,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd1921, 16'h0000}},
		'{OP_READ,  8'h00,  7'd0, 5'd24, GIVEN,   '{ST_DONE,    11'd1921, 16'hFF00}},
		'{OP_SET,   8'h00,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd0,    16'h0000}},
		'{OP_PUT,   8'h55,  7'd0,  5'd0, PREDICT, '0},
		// wrap from the end of the first row onto the second
		'{OP_SET,   8'h00, 7'd79,  5'd0, GIVEN,   '{ST_DONE,    11'd79,   16'h0000}},
		'{OP_PUT,   8'hAA,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd80,   16'h0000}},
		'{OP_READ,  8'h00, 7'd79,  5'd0, GIVEN,   '{ST_DONE,    11'd80,   16'hFFAA}},
		'{OP_READ,  8'h00,  7'd1,  5'd0, PREDICT, '0},
		// clear: blank everywhere, and puts now carry the fill attribute
		'{OP_CLEAR, 8'h00,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd0,    16'h0000}},
		'{OP_READ,  8'h00, 7'd40, 5'd12, GIVEN,   '{ST_DONE,    11'd0,    16'h00FF}},
		'{OP_PUT,   8'h41,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd1,    16'h0000}},
		'{OP_READ,  8'h00,  7'd0,  5'd0, GIVEN,   '{ST_DONE,    11'd1,    16'h0041}},
		'{OP_READ,  8'h00, 7'd79, 5'd24, GIVEN,   '{ST_DONE,    11'd1,    16'h00FF}},
		'{OP_SET,   8'h00, 7'd79, 5'd31, GIVEN,   '{ST_OUTSIDE, 11'd1,    16'h0000}}
	};

	// Advance the console copy by one command and return the response it owes.
	function automatic result_t console_apply(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
			logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		result_t r;
		cell_t   blank;
		logic    on_screen;
		r         = '0;
		blank     = {blank_attr, blank_char};
		on_screen = (int'(col) < COLUMNS) && (int'(row) < ROWS);
		case (op)
		OP_PUT: begin
			screen_copy[int'(cursor_row) * COLUMNS + int'(cursor_col)] = {put_attr, ch};
			if (int'(cursor_col) + 1 >= COLUMNS) begin
				cursor_col = '0;
				if (int'(cursor_row) + 1 >= ROWS) begin
					// scroll up one row and blank the bottom one
					for (int i = 0; i < MOVE_CELLS; i++)
						screen_copy[i] = screen_copy[i + COLUMNS];
					for (int i = MOVE_CELLS; i < CELLS; i++)
						screen_copy[i] = blank;
				end else begin
					cursor_row = cursor_row + 1'b1;
				end
			end else begin
				cursor_col = cursor_col + 1'b1;
			end
		end
		OP_CLEAR: begin
			put_attr   = blank_attr;
			cursor_col = '0;
			cursor_row = '0;
			for (int i = 0; i < CELLS; i++)
				screen_copy[i] = blank;
		end
		OP_SET: begin
			if (on_screen) begin
				cursor_col = col;
				cursor_row = row;
			end else begin
				r.status = ST_OUTSIDE;
			end
		end
		default: begin
			if (on_screen)
				r.cell_data = screen_copy[int'(row) * COLUMNS + int'(col)];
			else
				r.status = ST_OUTSIDE;
		end
		endcase
		r.cursor_index = IDX_W'(int'(cursor_row) * COLUMNS + int'(cursor_col));
		return r;
	endfunction

	// Mostly no gap, some short ones, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Both channels are watched here: a command beat feeds the predictor, a response
	// beat is checked against the oldest owed response.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n === 1'b1) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = console_apply(cmd_ch.operation, cmd_ch.character, cmd_ch.column,
					cmd_ch.row);
				due_responses.push_back(given_next ? given_res : want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.cursor_index, rsp_ch.cell_data};
				if (due_responses.size() == 0) begin
					$display("%0t: response beat with none owed: %h", $time, got);
					errors++;
				end else begin
					want = due_responses.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, got.status);
						errors++;
					end
					if (got.cursor_index !== want.cursor_index) begin
						$display("%0t: cursor_index expected %0d got %0d", $time,
							want.cursor_index, got.cursor_index);
						errors++;
					end
					if (got.cell_data !== want.cell_data) begin
						$display("%0t: cell_data expected %h got %h", $time,
							want.cell_data, got.cell_data);
						errors++;
					end
				end
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_text_console_writer_core: errors");
		$finish;
	end

	// Response side: hold ready low for random stretches unless the phase runs smooth.
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				ready_hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!smooth)
					ready_hold = pick_gap();
			end
		end
	end

	// Offer one command beat after an optional gap and hold it until taken.
	task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
			logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic given, result_t res);
		int gap;
		gap = smooth ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.character <= ch;
		cmd_ch.column    <= col;
		cmd_ch.row       <= row;
		given_next = given;
		given_res  = res;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and hold off until every owed response has come back.
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (due_responses.size() != 0)
			@(posedge clk);
	endtask

	// Write all three registers plus the spare index, then mirror them.
	task automatic program_regs(logic [BYTE_W-1:0] wa, logic [BYTE_W-1:0] fa,
			logic [BYTE_W-1:0] fc);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WRITE_ATTR;
		cfg_data  <= wa;
		@(negedge clk);
		cfg_index <= CFG_FILL_ATTR;
		cfg_data  <= fa;
		@(negedge clk);
		cfg_index <= CFG_FILL_CHAR;
		cfg_data  <= fc;
		@(negedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= BYTE_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		put_attr   = wa;
		blank_attr = fa;
		blank_char = fc;
	endtask

	initial begin
		int               kind;
		int               n;
		logic [COL_W-1:0] lc;
		logic [ROW_W-1:0] lr;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_WRITE_ATTR;
		cfg_data         = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.operation = OP_PUT;
		cmd_ch.character = '0;
		cmd_ch.column    = '0;
		cmd_ch.row       = '0;

		for (int i = 0; i < CELLS; i++)
			screen_copy[i] = '0;
		cursor_col = '0;
		cursor_row = '0;
		put_attr   = WRITE_ATTR_RST;
		blank_attr = FILL_ATTR_RST;
		blank_char = FILL_CHAR_RST;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The block zeroes its store after reset with cmd.ready low; registers are
		// taken meanwhile, and the first beat simply waits for ready.
		program_regs(8'hFF, 8'h00, 8'hFF);
		for (int i = 0; i < DIR_N; i++)
			send_item(directed_steps[i].op, directed_steps[i].ch, directed_steps[i].col,
				directed_steps[i].row, directed_steps[i].given, directed_steps[i].res);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			// first phase takes the opposite extremes, later ones random settings
			if (p == 0)
				program_regs(8'h00, 8'hFF, 8'h00);
			else
				program_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
			smooth = (p == 2);
			while (items_sent < DIR_N + (p + 1) * PHASE_ITEMS) begin
				kind = $urandom_range(0, 99);
				if (kind < 55) begin
					// a line of text: place the cursor, type, read back; often near
					// the end of the last row so that the screen scrolls
					if ($urandom_range(0, 9) < 3) begin
						lc = COL_W'($urandom_range(COLUMNS / 2, COLUMNS - 1));
						lr = ROW_W'(ROWS - 1);
					end else begin
						lc = COL_W'($urandom_range(0, COLUMNS - 1));
						lr = ROW_W'($urandom_range(0, ROWS - 1));
					end
					send_item(OP_SET, BYTE_W'($urandom), lc, lr, PREDICT, '0);
					n = $urandom_range(1, 40);
					repeat (n)
						send_item(OP_PUT, BYTE_W'($urandom), COL_W'($urandom),
							ROW_W'($urandom), PREDICT, '0);
					send_item(OP_READ, BYTE_W'($urandom), lc, lr, PREDICT, '0);
					repeat ($urandom_range(0, 3))
						send_item(OP_READ, BYTE_W'($urandom),
							COL_W'($urandom_range(0, COLUMNS - 1)),
							ROW_W'($urandom_range(0, ROWS - 1)), PREDICT, '0);
				end else if (kind < 63) begin
					// clear, type a little, then look at the corners and elsewhere
					send_item(OP_CLEAR, BYTE_W'($urandom), COL_W'($urandom),
						ROW_W'($urandom), PREDICT, '0);
					repeat ($urandom_range(1, 5))
						send_item(OP_PUT, BYTE_W'($urandom), COL_W'($urandom),
							ROW_W'($urandom), PREDICT, '0);
					send_item(OP_READ, BYTE_W'($urandom), '0, '0, PREDICT, '0);
					send_item(OP_READ, BYTE_W'($urandom), COL_W'(COLUMNS - 1),
						ROW_W'(ROWS - 1), PREDICT, '0);
					send_item(OP_READ, BYTE_W'($urandom),
						COL_W'($urandom_range(0, COLUMNS - 1)),
						ROW_W'($urandom_range(0, ROWS - 1)), PREDICT, '0);
				end else if (kind < 75) begin
					repeat ($urandom_range(2, 8))
						send_item(OP_READ, BYTE_W'($urandom),
							COL_W'($urandom_range(0, COLUMNS - 1)),
							ROW_W'($urandom_range(0, ROWS - 1)), PREDICT, '0);
				end else begin
					// noise over the whole field ranges, off-screen positions included
					repeat ($urandom_range(1, 6))
						send_item(OP_W'($urandom), BYTE_W'($urandom), COL_W'($urandom),
							ROW_W'($urandom), PREDICT, '0);
				end
			end
			drain();
		end

		smooth = 1'b0;
		repeat (20) @(posedge clk);
		if (errors == 0 && due_responses.size() == 0) begin
			$display("tb_text_console_writer_core: clean");
		end else begin
			$display("%0t: %0d responses still owed", $time, due_responses.size());
			$display("tb_text_console_writer_core: errors");
		end
		$finish;
	end

endmodule

// ===== text_console_writer_core.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_screen_mem.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer_core.sv
rtl/core/tcw_checker.sv
verif/tb_text_console_writer_core.sv
